// ----- rtl/dhlrf_pkg.sv -----
// ----------------------------------------------------------------------------
// dhlrf_pkg
// Shared types, constants and the segment table of the two-lane hex display
// refresh framer.
// ----------------------------------------------------------------------------
package dhlrf_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [7:0]  CmdDisplayCtl = 8'h88;
  localparam logic [7:0]  CmdData       = 8'h40;
  localparam logic [7:0]  CmdAddress    = 8'hC0;
  localparam logic [7:0]  GapByte       = 8'h00;
  localparam logic [15:0] BlankValue    = 16'hFFFF;
  localparam logic [2:0]  BrightReset   = 3'd3;

  localparam logic [0:0]  RegBrightness = 1'b0;

  localparam logic [2:0]  StepFirst     = 3'd0;
  localparam logic [2:0]  StepInitLast  = 3'd1;
  localparam logic [2:0]  StepLast      = 3'd7;

  typedef enum logic {
    CMD_REFRESH = 1'b0,
    CMD_INIT    = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  ctl;
    logic [15:0] left;
    logic [15:0] right;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] seg_code(input logic [3:0] nib);
    logic [7:0] code;
    case (nib)
      4'h0:    code = 8'h1E;
      4'h1:    code = 8'h28;
      4'h2:    code = 8'hB6;
      4'h3:    code = 8'hBC;
      4'h4:    code = 8'h78;
      4'h5:    code = 8'hDC;
      4'h6:    code = 8'hDE;
      4'h7:    code = 8'hE8;
      4'h8:    code = 8'hFE;
      4'h9:    code = 8'hFC;
      4'hA:    code = 8'hFA;
      4'hB:    code = 8'h5E;
      4'hC:    code = 8'hC6;
      4'hD:    code = 8'h3E;
      4'hE:    code = 8'hD6;
      4'hF:    code = 8'hD2;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [3:0] nibble_at(input logic [15:0] v, input logic [1:0] idx);
    logic [3:0] n;
    case (idx)
      2'd0:    n = v[3:0];
      2'd1:    n = v[7:4];
      2'd2:    n = v[11:8];
      2'd3:    n = v[15:12];
      default: n = 4'h0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/dual_hex_led_refresh_framer_core.sv -----
// ----------------------------------------------------------------------------
// dual_hex_led_refresh_framer_core
// Two-lane refresh framer for a pair of four-digit hex LED displays.
//
//   channel  direction  handshake                 payload
//   input    in         in_valid_i / in_ready_o   mode, left_value, right_value
//   output   out        out_valid_o / out_ready_i lane1/2 bytes, frame flags, last
//   config   in         APB psel/penable/pready   brightness_level at 0x0
//
// A refresh with new values gives eight bytes, one per cycle unless stalled; an
// init gives two; a refresh with unchanged values gives none and is not queued.
// The byte sequencer, one byte per cycle while not stalled, sets the rate.
// Reset: shown values 0xffff, brightness 3, queue and output register empty.
// A two-entry queue lets input acceptance and output stalls proceed apart.
// ----------------------------------------------------------------------------
module dual_hex_led_refresh_framer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [15:0] left_value_i,
  input  logic [15:0] right_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  lane1_byte_o,
  output logic [7:0]  lane2_byte_o,
  output logic        frame_begin_o,
  output logic        frame_end_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 bright_we;
  logic [2:0]           bright_q, bright_d;
  logic                 push;
  logic                 pop;
  dhlrf_pkg::cmd_t      push_cmd;
  dhlrf_pkg::cmd_t      head;
  dhlrf_pkg::q_status_t q_status;

  assign pready    = 1'b1;
  assign bright_we = psel && penable && pwrite && pready
                     && (paddr[2] == dhlrf_pkg::RegBrightness);
  assign bright_d  = bright_we ? pwdata[2:0] : bright_q;
  assign prdata    = (paddr[2] == dhlrf_pkg::RegBrightness) ? {29'd0, bright_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= dhlrf_pkg::BrightReset;
    end else begin
      bright_q <= bright_d;
    end
  end

  dhlrf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .left_value_i  (left_value_i),
    .right_value_i (right_value_i),
    .brightness_i  (bright_q),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  dhlrf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  dhlrf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lane1_byte_o  (lane1_byte_o),
    .lane2_byte_o  (lane2_byte_o),
    .frame_begin_o (frame_begin_o),
    .frame_end_o   (frame_end_o),
    .last_o        (last_o)
  );

endmodule

// ----- rtl/dhlrf_front.sv -----
// ----------------------------------------------------------------------------
// dhlrf_front
// Accepts items, compares refresh values with the shown values and queues
// the commands that need bytes on the lanes.
// ----------------------------------------------------------------------------
module dhlrf_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  input  logic [15:0]          left_value_i,
  input  logic [15:0]          right_value_i,
  input  logic [2:0]           brightness_i,
  input  dhlrf_pkg::q_status_t q_status_i,
  output logic                 push_o,
  output dhlrf_pkg::cmd_t      push_cmd_o
);

  logic [15:0] shown_left_q, shown_left_d;
  logic [15:0] shown_right_q, shown_right_d;
  logic        accept;
  logic        changed;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign changed    = (left_value_i != shown_left_q) || (right_value_i != shown_right_q);

  always_comb begin
    shown_left_d     = shown_left_q;
    shown_right_d    = shown_right_q;
    push_o           = 1'b0;
    push_cmd_o.kind  = dhlrf_pkg::CMD_REFRESH;
    push_cmd_o.ctl   = dhlrf_pkg::CmdDisplayCtl | {5'd0, brightness_i};
    push_cmd_o.left  = left_value_i;
    push_cmd_o.right = right_value_i;
    if (accept) begin
      if (mode_i) begin
        shown_left_d    = dhlrf_pkg::BlankValue;
        shown_right_d   = dhlrf_pkg::BlankValue;
        push_o          = 1'b1;
        push_cmd_o.kind = dhlrf_pkg::CMD_INIT;
      end else if (changed) begin
        shown_left_d  = left_value_i;
        shown_right_d = right_value_i;
        push_o        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_left_q  <= dhlrf_pkg::BlankValue;
      shown_right_q <= dhlrf_pkg::BlankValue;
    end else begin
      shown_left_q  <= shown_left_d;
      shown_right_q <= shown_right_d;
    end
  end

endmodule

// ----- rtl/dhlrf_queue.sv -----
// ----------------------------------------------------------------------------
// dhlrf_queue
// Two-entry command queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module dhlrf_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dhlrf_pkg::cmd_t      push_cmd_i,
  input  logic                 pop_i,
  output dhlrf_pkg::cmd_t      head_o,
  output dhlrf_pkg::q_status_t status_o
);

  dhlrf_pkg::cmd_t                     mem_q [dhlrf_pkg::QueueDepth];
  logic [dhlrf_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [dhlrf_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [dhlrf_pkg::QueueCntW-1:0]     count_q, count_d;
  logic                                do_push;
  logic                                do_pop;

  assign status_o.full  = (count_q == dhlrf_pkg::QueueCntW'(dhlrf_pkg::QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ----- rtl/dhlrf_back.sv -----
// ----------------------------------------------------------------------------
// dhlrf_back
// Byte sequencer: walks the queued command one byte per cycle into the
// output register, holding while the output is stalled.
// ----------------------------------------------------------------------------
module dhlrf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dhlrf_pkg::cmd_t      head_i,
  input  dhlrf_pkg::q_status_t q_status_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           lane1_byte_o,
  output logic [7:0]           lane2_byte_o,
  output logic                 frame_begin_o,
  output logic                 frame_end_o,
  output logic                 last_o
);

  logic [2:0] step_q, step_d;
  logic       valid_q, valid_d;
  logic [7:0] lane1_q, lane1_d;
  logic [7:0] lane2_q, lane2_d;
  logic       begin_q, begin_d;
  logic       end_q, end_d;
  logic       last_q, last_d;
  logic       advance;
  logic [1:0] digit;

  assign advance = (!valid_q || out_ready_i) && !q_status_i.empty;
  assign digit   = step_q[2:1];

  always_comb begin
    step_d  = step_q;
    valid_d = valid_q && !out_ready_i;
    lane1_d = lane1_q;
    lane2_d = lane2_q;
    begin_d = begin_q;
    end_d   = end_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (advance) begin
      valid_d = 1'b1;
      begin_d = 1'b0;
      end_d   = 1'b0;
      last_d  = 1'b0;
      if (head_i.kind == dhlrf_pkg::CMD_INIT) begin
        begin_d = 1'b1;
        end_d   = 1'b1;
        if (step_q == dhlrf_pkg::StepFirst) begin
          lane1_d = head_i.ctl;
          lane2_d = head_i.ctl;
          step_d  = step_q + 3'd1;
        end else begin
          lane1_d = dhlrf_pkg::CmdData;
          lane2_d = dhlrf_pkg::CmdData;
          last_d  = 1'b1;
          step_d  = dhlrf_pkg::StepFirst;
          pop_o   = 1'b1;
        end
      end else begin
        if (step_q == dhlrf_pkg::StepFirst) begin
          lane1_d = dhlrf_pkg::CmdAddress;
          lane2_d = dhlrf_pkg::CmdAddress;
          begin_d = 1'b1;
        end else if (step_q[0]) begin
          lane1_d = dhlrf_pkg::seg_code(dhlrf_pkg::nibble_at(head_i.left, digit));
          lane2_d = dhlrf_pkg::seg_code(dhlrf_pkg::nibble_at(head_i.right, digit));
        end else begin
          lane1_d = dhlrf_pkg::GapByte;
          lane2_d = dhlrf_pkg::GapByte;
        end
        if (step_q == dhlrf_pkg::StepLast) begin
          end_d  = 1'b1;
          last_d = 1'b1;
          step_d = dhlrf_pkg::StepFirst;
          pop_o  = 1'b1;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= dhlrf_pkg::StepFirst;
      valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lane1_q <= lane1_d;
    lane2_q <= lane2_d;
    begin_q <= begin_d;
    end_q   <= end_d;
    last_q  <= last_d;
  end

  assign out_valid_o   = valid_q;
  assign lane1_byte_o  = lane1_q;
  assign lane2_byte_o  = lane2_q;
  assign frame_begin_o = begin_q;
  assign frame_end_o   = end_q;
  assign last_o        = last_q;

endmodule

// ----- tb/tb_dual_hex_led_refresh_framer_core.sv -----
// ----------------------------------------------------------------------------
// tb_dual_hex_led_refresh_framer_core
// Drives init and refresh items into the framer and checks every output byte
// against a predicted display frame. Covers brightness setting over the APB
// port, back-pressure and idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_dual_hex_led_refresh_framer_core;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned PhaseItems   = 160;
  localparam int unsigned MaxPrinted   = 40;

  localparam logic [2:0] AddrBrightness = {dhlrf_pkg::RegBrightness, 2'b00};
  localparam logic [2:0] AddrSpare      = 3'h4;

  localparam logic [127:0] SegTable = {
    8'hD2, 8'hD6, 8'h3E, 8'hC6, 8'h5E, 8'hFA, 8'hFC, 8'hFE,
    8'hE8, 8'hDE, 8'hDC, 8'h78, 8'hBC, 8'hB6, 8'h28, 8'h1E
  };

  class frame_predictor;
    logic [15:0] shown_l;
    logic [15:0] shown_r;
    logic [2:0]  bright;
    logic [18:0] due_bytes[$];
    int unsigned n_fail;

    function new();
      shown_l = dhlrf_pkg::BlankValue;
      shown_r = dhlrf_pkg::BlankValue;
      bright  = dhlrf_pkg::BrightReset;
      n_fail  = 0;
    endfunction

    function int unsigned pending();
      return due_bytes.size();
    endfunction

    function void push(logic [7:0] l1, logic [7:0] l2, logic fb, logic fe, logic fin);
      due_bytes.push_back({l1, l2, fb, fe, fin});
    endfunction

    function logic [7:0] seg_of(logic [3:0] nib);
      return SegTable[nib*8 +: 8];
    endfunction

    function void note_item(dhlrf_pkg::cmd_kind_e kind, logic [15:0] lv,
                            logic [15:0] rv);
      logic [7:0] ctl;
      if (kind == dhlrf_pkg::CMD_INIT) begin
        ctl     = dhlrf_pkg::CmdDisplayCtl | {5'b0, bright};
        shown_l = dhlrf_pkg::BlankValue;
        shown_r = dhlrf_pkg::BlankValue;
        push(ctl, ctl, 1'b1, 1'b1, 1'b0);
        push(dhlrf_pkg::CmdData, dhlrf_pkg::CmdData, 1'b1, 1'b1, 1'b1);
        return;
      end
      if (lv == shown_l && rv == shown_r) return;
      shown_l = lv;
      shown_r = rv;
      push(dhlrf_pkg::CmdAddress, dhlrf_pkg::CmdAddress, 1'b1, 1'b0, 1'b0);
      for (int d = 0; d < 4; d++) begin
        if (d > 0) push(dhlrf_pkg::GapByte, dhlrf_pkg::GapByte, 1'b0, 1'b0, 1'b0);
        push(seg_of(lv[d*4 +: 4]), seg_of(rv[d*4 +: 4]), 1'b0, d == 3, d == 3);
      end
    endfunction

    task report(string msg);
      n_fail++;
      if (n_fail <= MaxPrinted) $display("MISMATCH: %s", msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h, want %0h", name, got, want));
    endtask

    task check_byte(logic [7:0] l1, logic [7:0] l2, logic fb, logic fe, logic fin);
      logic [18:0] want;
      if (due_bytes.size() == 0) begin
        report($sformatf("unexpected byte %0h/%0h", l1, l2));
        return;
      end
      want = due_bytes.pop_front();
      compare_field("lane1_byte", l1, want[18:11]);
      compare_field("lane2_byte", l2, want[10:3]);
      compare_field("frame_begin", {7'd0, fb}, {7'd0, want[2]});
      compare_field("frame_end", {7'd0, fe}, {7'd0, want[1]});
      compare_field("last", {7'd0, fin}, {7'd0, want[0]});
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        mode_i;
  logic [15:0] left_value_i;
  logic [15:0] right_value_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  lane1_byte_o;
  logic [7:0]  lane2_byte_o;
  logic        frame_begin_o;
  logic        frame_end_o;
  logic        last_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_predictor pred;
  int unsigned    send_idle;
  int unsigned    recv_idle;
  int unsigned    hold_req;
  int unsigned    cycle_count;

  dual_hex_led_refresh_framer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .left_value_i  (left_value_i),
    .right_value_i (right_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .lane1_byte_o  (lane1_byte_o),
    .lane2_byte_o  (lane2_byte_o),
    .frame_begin_o (frame_begin_o),
    .frame_end_o   (frame_end_o),
    .last_o        (last_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_req) @(negedge clk_i);
        hold_req = 0;
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      pred.check_byte(lane1_byte_o, lane2_byte_o, frame_begin_o, frame_end_o, last_o);
    end
  end

  task automatic send_item(input dhlrf_pkg::cmd_kind_e kind, input logic [15:0] lv,
                           input logic [15:0] rv);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= kind;
    left_value_i  <= lv;
    right_value_i <= rv;
    do @(posedge clk_i); while (!in_ready_o);
    pred.note_item(kind, lv, rv);
    @(negedge clk_i);
  endtask

  task automatic send_random_item();
    int unsigned pick;
    logic [15:0] lv;
    logic [15:0] rv;
    pick = $urandom_range(0, 99);
    lv   = 16'($urandom);
    rv   = 16'($urandom);
    if (pick < 8) begin
      send_item(dhlrf_pkg::CMD_INIT, lv, rv);
    end else begin
      if (pick < 20) begin
        lv = pred.shown_l;
        rv = pred.shown_r;
      end else if (pick < 30) begin
        lv = pred.shown_l;
      end else if (pick < 40) begin
        rv = pred.shown_r;
      end
      send_item(dhlrf_pkg::CMD_REFRESH, lv, rv);
    end
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pred.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [2:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
  endtask

  task automatic write_config(input logic [2:0] addr, input logic [31:0] wdata);
    logic [31:0] rd;
    apb_xfer(1'b1, addr, wdata, rd);
    if (addr == AddrBrightness) pred.bright = wdata[2:0];
    apb_xfer(1'b0, AddrBrightness, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[2:0] !== pred.bright) begin
      pred.report($sformatf("brightness read %0d, want %0d", rd[2:0], pred.bright));
    end
  endtask

  task automatic set_brightness(input logic [2:0] level);
    logic [31:0] w;
    w      = $urandom;
    w[2:0] = level;
    write_config(AddrBrightness, w);
  endtask

  initial begin
    pred          = new();
    send_idle     = 37;
    recv_idle     = 60;
    hold_req      = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = 1'b0;
    left_value_i  = '0;
    right_value_i = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_item(dhlrf_pkg::CMD_INIT, 16'($urandom), 16'($urandom));
    send_item(dhlrf_pkg::CMD_REFRESH, 16'hFFFF, 16'hFFFF);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'h0000, 16'h0000);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'h0000, 16'h0000);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'h0123, 16'h4567);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'h89AB, 16'hCDEF);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'h89AB, 16'h0000);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'h1111, 16'h0000);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'hFEDC, 16'hBA98);
    send_item(dhlrf_pkg::CMD_INIT, 16'hFFFF, 16'hFFFF);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'hFFFF, 16'hFFFF);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'hFFFF, 16'h0000);
    send_item(dhlrf_pkg::CMD_REFRESH, 16'h5A5A, 16'hA5A5);
    wait_quiet();
    set_brightness(3'd7);
    send_item(dhlrf_pkg::CMD_INIT, 16'h0000, 16'h0000);
    wait_quiet();
    set_brightness(3'd0);
    send_item(dhlrf_pkg::CMD_INIT, 16'($urandom), 16'($urandom));
    wait_quiet();
    write_config(AddrSpare, $urandom);
    send_item(dhlrf_pkg::CMD_INIT, 16'($urandom), 16'($urandom));
    send_item(dhlrf_pkg::CMD_REFRESH, 16'h7E81, 16'h18E7);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 37 : (ph == 1) ? 60 : 0;
      recv_idle = (ph == 0) ? 60 : (ph == 1) ? 37 : 0;
      wait_quiet();
      set_brightness(3'($urandom_range(0, 7)));
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 0 && n == 40) hold_req = HoldCycles;
        if (ph == 0 && n == 100) wait_quiet();
        send_random_item();
      end
    end

    wait_quiet();
    if (pred.n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dhlrf_pkg.sv
rtl/dhlrf_front.sv
rtl/dhlrf_queue.sv
rtl/dhlrf_back.sv
rtl/dual_hex_led_refresh_framer_core.sv
tb/tb_dual_hex_led_refresh_framer_core.sv
